@@ src/radio_packet_receive_checker_defines.svh @@
// ----------------------------------------------------------------------------
// Radio packet receive checker - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RADIO_PACKET_RECEIVE_CHECKER_DEFINES_SVH
`define RADIO_PACKET_RECEIVE_CHECKER_DEFINES_SVH

// clocked property, ignored while reset is held
`define RPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, also checked during reset
`define RPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/rpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Radio packet receive checker - package
// Codes, mode type and the CRC16 byte update.
// ----------------------------------------------------------------------------
package rpr_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_INIT  = 3'd0,
        CFG_CRC_POLY  = 3'd1,
        CFG_MAX_LEN   = 3'd2,
        CFG_BASE_ADDR = 3'd3,
        CFG_PREFIX    = 3'd4,
        CFG_FREQ      = 3'd5,
        CFG_IRQ_EN    = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TASK_RX_EN   = 2'd0,
        TASK_TX_EN   = 2'd1,
        TASK_START   = 2'd2,
        TASK_DISABLE = 2'd3
    } task_t;

    typedef enum logic [1:0] {
        KIND_STAGED   = 2'd0,
        KIND_STATUS   = 2'd1,
        KIND_READY    = 2'd2,
        KIND_DISABLED = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        MODE_DISABLED  = 4'b0001,
        MODE_TX_READY  = 4'b0010,
        MODE_RX_READY  = 4'b0100,
        MODE_RX_ACTIVE = 4'b1000
    } mode_t;

    localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
    localparam logic [7:0]  MAX_LEN_RESET  = 8'hff;

    // MSB-first CRC16 over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/radio_packet_receive_checker.sv @@
// ----------------------------------------------------------------------------
// Radio packet receive checker
// Radio mode control, air-frame deframing, address match and CRC16 check.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request per transfer: a task command or one
//   received air byte. m_ channel gives at most one result per request:
//   a staged length/payload byte, a frame status, a ready or a disabled
//   event. cfg channel writes the seven setup registers; write only idle.
// Timing:
//   One request per cycle sustained while m_tready is high. A request is held
//   in the input register, is decoded and updates mode, byte position and
//   CRC as it leaves it, and its result is registered in the output register.
//   The CRC16 byte update is the longest path.
// Reset (aresetn low, synchronous): mode disabled, no frame in progress,
//   setup registers at their defaults, both channels empty.
// Stall: with m_tready low a held result blocks the decode stage; the input
//   register still takes one more request, then s_tready falls.
// ----------------------------------------------------------------------------
module radio_packet_receive_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rpr_pkg::S_DATA_W-1:0]      s_tdata,   // air_byte, task_code
    input  logic [rpr_pkg::S_USER_W-1:0]      s_tuser,   // req_type, frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // packet_byte, packet_index, frame_accepted, crc_good, signal_strength
    output logic [rpr_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [rpr_pkg::M_USER_W-1:0]      m_tuser,   // out_kind
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rpr_pkg::*;

    // setup registers
    logic [15:0] crc_init_reg;
    logic [15:0] crc_poly_reg;
    logic [7:0]  max_len_reg;
    logic [31:0] base_addr_reg;
    logic [7:0]  prefix_reg;
    logic [7:0]  freq_reg;
    logic        irq_en_reg;

    // input register
    logic        in_valid_reg;
    logic        in_req_reg;
    logic        in_start_reg;
    logic [7:0]  in_byte_reg;
    logic [1:0]  in_task_reg;

    // frame state
    mode_t       mode_reg, mode_next;
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic        match_reg, match_next;

    // output register
    logic        out_valid_reg;
    kind_t       out_kind_reg, out_kind_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [7:0]  out_index_reg, out_index_next;
    logic        out_acc_reg, out_acc_next;
    logic        out_good_reg, out_good_next;
    logic [7:0]  out_rssi_reg, out_rssi_next;
    logic        has_result;

    logic        advance;
    logic        s_accept;
    logic        taking;
    logic [8:0]  p;
    logic [15:0] crc_base;
    logic        match_base;
    logic [15:0] crc_upd;
    logic [8:0]  len_cur;
    logic [8:0]  len_p5;
    logic [8:0]  p_m5;
    logic [7:0]  base_byte;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_init_reg  <= '0;
            crc_poly_reg  <= CRC_POLY_RESET;
            max_len_reg   <= MAX_LEN_RESET;
            base_addr_reg <= '0;
            prefix_reg    <= '0;
            freq_reg      <= '0;
            irq_en_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CRC_INIT:  crc_init_reg  <= cfg_data[15:0];
                CFG_CRC_POLY:  crc_poly_reg  <= cfg_data[15:0];
                CFG_MAX_LEN:   max_len_reg   <= cfg_data[7:0];
                CFG_BASE_ADDR: base_addr_reg <= cfg_data[31:0];
                CFG_PREFIX:    prefix_reg    <= cfg_data[7:0];
                CFG_FREQ:      freq_reg      <= cfg_data[7:0];
                CFG_IRQ_EN:    irq_en_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_req_reg   <= s_tuser[0];
            in_start_reg <= s_tuser[1];
            in_byte_reg  <= s_tdata[7:0];
            in_task_reg  <= s_tdata[9:8];
        end
    end

    assign taking = in_valid_reg && advance;

    // decode
    assign p          = in_start_reg ? 9'd0 : pos_reg;
    assign crc_base   = (p == 9'd0) ? crc_init_reg : crc_reg;
    assign match_base = (p == 9'd0) ? 1'b1 : match_reg;
    assign crc_upd    = crc16_byte(crc_base, in_byte_reg, crc_poly_reg);
    assign len_cur    = (p == 9'd5) ?
                        ({1'b0, (in_byte_reg > max_len_reg) ? max_len_reg : in_byte_reg}
                         + 9'd1) : len_reg;
    assign len_p5     = len_cur + 9'd5;
    assign p_m5       = p - 9'd5;
    assign base_byte  = base_addr_reg[{p[1:0], 3'b000} +: 8];

    always_comb begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        rcrc_next      = rcrc_reg;
        match_next     = match_reg;
        has_result     = 1'b0;
        out_kind_next  = KIND_STAGED;
        out_byte_next  = '0;
        out_index_next = '0;
        out_acc_next   = 1'b0;
        out_good_next  = 1'b0;
        out_rssi_next  = '0;
        if (in_req_reg) begin
            pos_next = '0;
            unique case (in_task_reg)
                TASK_RX_EN: begin
                    mode_next     = MODE_RX_READY;
                    has_result    = 1'b1;
                    out_kind_next = KIND_READY;
                end
                TASK_TX_EN: begin
                    mode_next     = MODE_TX_READY;
                    has_result    = 1'b1;
                    out_kind_next = KIND_READY;
                end
                TASK_START: begin
                    if (mode_reg == MODE_RX_READY) begin
                        mode_next = MODE_RX_ACTIVE;
                    end
                end
                TASK_DISABLE: begin
                    mode_next     = MODE_DISABLED;
                    has_result    = 1'b1;
                    out_kind_next = KIND_DISABLED;
                end
                default: ;
            endcase
        end else if (irq_en_reg && mode_reg == MODE_RX_ACTIVE
                     && (in_start_reg || pos_reg != 9'd0)) begin
            crc_next   = crc_base;
            match_next = match_base;
            len_next   = len_cur;
            if (p == 9'd0) begin
                rcrc_next = '0;
                len_next  = '0;
            end
            priority if (p < 9'd4) begin
                if (in_byte_reg != base_byte) begin
                    match_next = 1'b0;
                end
                crc_next = crc_upd;
                pos_next = p + 9'd1;
            end else if (p == 9'd4) begin
                if (in_byte_reg != prefix_reg) begin
                    match_next = 1'b0;
                end
                crc_next = crc_upd;
                pos_next = p + 9'd1;
            end else if (p < len_p5) begin
                crc_next       = crc_upd;
                pos_next       = p + 9'd1;
                has_result     = 1'b1;
                out_kind_next  = KIND_STAGED;
                out_byte_next  = in_byte_reg;
                out_index_next = p_m5[7:0];
            end else if (p == len_p5) begin
                rcrc_next = {in_byte_reg, 8'h00};
                pos_next  = p + 9'd1;
            end else if (p == len_p5 + 9'd1) begin
                rcrc_next = {rcrc_reg[15:8], in_byte_reg};
                pos_next  = p + 9'd1;
            end else if (p == len_p5 + 9'd2) begin
                if (in_byte_reg != freq_reg) begin
                    match_next = 1'b0;
                end
                pos_next = p + 9'd1;
            end else begin
                pos_next      = '0;
                has_result    = 1'b1;
                out_kind_next = KIND_STATUS;
                out_acc_next  = match_base;
                out_good_next = (rcrc_reg == crc_reg);
                out_rssi_next = in_byte_reg;
                if (match_base) begin
                    mode_next = MODE_RX_READY;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_DISABLED;
            pos_reg   <= '0;
            len_reg   <= '0;
            crc_reg   <= '0;
            rcrc_reg  <= '0;
            match_reg <= 1'b1;
        end else if (taking) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (taking && has_result) begin
            out_kind_reg  <= out_kind_next;
            out_byte_reg  <= out_byte_next;
            out_index_reg <= out_index_next;
            out_acc_reg   <= out_acc_next;
            out_good_reg  <= out_good_next;
            out_rssi_reg  <= out_rssi_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'b000000, out_rssi_reg, out_good_reg, out_acc_reg,
                       out_index_reg, out_byte_reg};

endmodule

@@ src/rpr_checker.sv @@
// ----------------------------------------------------------------------------
// Radio packet receive checker - port checker
// Output channel behaviour and input stall seen from the top level's ports.
// ----------------------------------------------------------------------------
`include "radio_packet_receive_checker_defines.svh"

module rpr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rpr_pkg::M_DATA_W-1:0]      m_tdata,
    input logic [rpr_pkg::M_USER_W-1:0]      m_tuser
);
    import rpr_pkg::*;

    `RPR_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `RPR_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    `RPR_ASSERT(a_staged_clean, aclk, aresetn, m_tvalid && m_tuser == KIND_STAGED |-> m_tdata[M_DATA_W-1:16] == '0, "staged byte carries status bits")

    `RPR_ASSERT(a_event_clean, aclk, aresetn, m_tvalid && (m_tuser == KIND_READY || m_tuser == KIND_DISABLED) |-> m_tdata == '0, "mode event carries data")

    `RPR_ASSERT(a_in_stall, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready, "input stalled without a held result")

endmodule

bind radio_packet_receive_checker rpr_checker u_rpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
